### src/point_set_bounding_box_macros.svh
// ----------------------------------------------------------------------------
// point_set_bounding_box assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_SET_BOUNDING_BOX_MACROS_SVH
`define POINT_SET_BOUNDING_BOX_MACROS_SVH

// same-cycle implication
`define PSBB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/psbb_pkg.sv
// ----------------------------------------------------------------------------
// psbb_pkg
// Shared types and constants of the point set bounding box block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psbb_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CLIP_ENABLE = 3'd0,
        REG_CLIP_LEFT   = 3'd1,
        REG_CLIP_TOP    = 3'd2,
        REG_CLIP_WIDTH  = 3'd3,
        REG_CLIP_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic counts;
        logic last;
    } t_stage_ctl;

endpackage

### src/point_set_bounding_box.sv
// ----------------------------------------------------------------------------
// point_set_bounding_box
// Running bounding box of a point stream with optional clip window.
//
// channel  direction  handshake             payload
// in       input      i_in_valid/o_in_stall  point_x, point_y, is_last
// out      output     o_out_valid/i_out_stall found, box_x/y/w/h
// cfg      input      i_cfg_valid/o_cfg_ready cfg_index, cfg_data
//
// One point per cycle while o_in_stall is low. The result of a set passes the
// input register, then the box and result register, once its last point is in.
// Reset clears the clip registers, the box-started flag and both stage valids.
// A stalled result holds the pipeline; an empty input register still fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_set_bounding_box_macros.svh"

module point_set_bounding_box
    import psbb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_is_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic signed [COORD_BITS-1:0] o_box_x,
    output logic signed [COORD_BITS-1:0] o_box_y,
    output logic [COORD_BITS:0]          o_box_w,
    output logic [COORD_BITS:0]          o_box_h,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data
);

    logic                         clip_enable;
    logic signed [COORD_BITS-1:0] clip_left;
    logic signed [COORD_BITS-1:0] clip_top;
    logic [COORD_BITS-1:0]        clip_width;
    logic [COORD_BITS-1:0]        clip_height;
    logic                         counts;
    logic                         advance;
    logic                         in_take;

    t_stage_ctl                   r_s1;
    logic signed [COORD_BITS-1:0] r_s1_x;
    logic signed [COORD_BITS-1:0] r_s1_y;

    assign o_cfg_ready = 1'b1;

    psbb_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_clip_enable (clip_enable),
        .o_clip_left   (clip_left),
        .o_clip_top    (clip_top),
        .o_clip_width  (clip_width),
        .o_clip_height (clip_height)
    );

    psbb_clip #(.COORD_BITS(COORD_BITS)) u_clip (
        .i_clip_enable (clip_enable),
        .i_clip_left   (clip_left),
        .i_clip_top    (clip_top),
        .i_clip_width  (clip_width),
        .i_clip_height (clip_height),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_counts      (counts)
    );

    assign advance    = !(o_out_valid && i_out_stall);
    assign o_in_stall = r_s1.valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (in_take) begin
            r_s1.valid  <= 1'b1;
            r_s1.counts <= counts;
            r_s1.last   <= i_is_last;
        end else if (advance) begin
            r_s1.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_x <= i_point_x;
            r_s1_y <= i_point_y;
        end
    end

    psbb_accum #(.COORD_BITS(COORD_BITS)) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s1),
        .i_advance   (advance),
        .i_point_x   (r_s1_x),
        .i_point_y   (r_s1_y),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_box_x     (o_box_x),
        .o_box_y     (o_box_y),
        .o_box_w     (o_box_w),
        .o_box_h     (o_box_h)
    );

    `PSBB_ASSERT_SAME(a_empty_box_zero, o_out_valid && !o_found, (o_box_x == '0) && (o_box_y == '0) && (o_box_w == '0) && (o_box_h == '0), "empty set result has nonzero box")
    `PSBB_ASSERT_SAME(a_found_size_nonzero, o_out_valid && o_found, (o_box_w != '0) && (o_box_h != '0), "found box has zero size")
    `PSBB_ASSERT_NEXT(a_result_from_last, !o_out_valid && !(r_s1.valid && r_s1.last && advance), !o_out_valid, "result without a last point")

endmodule

### src/psbb_cfg.sv
// ----------------------------------------------------------------------------
// psbb_cfg
// Clip window configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psbb_cfg
    import psbb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    output logic                         o_clip_enable,
    output logic signed [COORD_BITS-1:0] o_clip_left,
    output logic signed [COORD_BITS-1:0] o_clip_top,
    output logic [COORD_BITS-1:0]        o_clip_width,
    output logic [COORD_BITS-1:0]        o_clip_height
);

    logic                         r_enable;
    logic signed [COORD_BITS-1:0] r_left;
    logic signed [COORD_BITS-1:0] r_top;
    logic [COORD_BITS-1:0]        r_width;
    logic [COORD_BITS-1:0]        r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_CLIP_ENABLE: r_enable <= i_cfg_data[0];
                REG_CLIP_LEFT:   r_left   <= $signed(i_cfg_data);
                REG_CLIP_TOP:    r_top    <= $signed(i_cfg_data);
                REG_CLIP_WIDTH:  r_width  <= i_cfg_data;
                REG_CLIP_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_clip_enable = r_enable;
    assign o_clip_left   = r_left;
    assign o_clip_top    = r_top;
    assign o_clip_width  = r_width;
    assign o_clip_height = r_height;

endmodule

### src/psbb_clip.sv
// ----------------------------------------------------------------------------
// psbb_clip
// Decides whether a point counts against the inclusive clip window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psbb_clip
    import psbb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clip_enable,
    input  logic signed [COORD_BITS-1:0] i_clip_left,
    input  logic signed [COORD_BITS-1:0] i_clip_top,
    input  logic [COORD_BITS-1:0]        i_clip_width,
    input  logic [COORD_BITS-1:0]        i_clip_height,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_counts
);

    localparam int EW = COORD_BITS + 2;

    logic signed [EW-1:0] px_e;
    logic signed [EW-1:0] py_e;
    logic signed [EW-1:0] left_e;
    logic signed [EW-1:0] top_e;
    logic signed [EW-1:0] right_e;
    logic signed [EW-1:0] bottom_e;
    logic                 in_win;
    logic                 empty;

    always_comb begin
        px_e     = EW'(i_point_x);
        py_e     = EW'(i_point_y);
        left_e   = EW'(i_clip_left);
        top_e    = EW'(i_clip_top);
        // exact edges, no wrap
        right_e  = left_e + $signed({2'b00, i_clip_width}) - $signed(EW'(1));
        bottom_e = top_e + $signed({2'b00, i_clip_height}) - $signed(EW'(1));
        empty    = (i_clip_width == '0) || (i_clip_height == '0);
        in_win   = (px_e >= left_e) && (px_e <= right_e) &&
                   (py_e >= top_e) && (py_e <= bottom_e);
        o_counts = !i_clip_enable || (!empty && in_win);
    end

endmodule

### src/psbb_accum.sv
// ----------------------------------------------------------------------------
// psbb_accum
// Running min/max box of counted points and the registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psbb_accum
    import psbb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_stage_ctl                   i_ctl,
    input  logic                         i_advance,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_found,
    output logic signed [COORD_BITS-1:0] o_box_x,
    output logic signed [COORD_BITS-1:0] o_box_y,
    output logic [COORD_BITS:0]          o_box_w,
    output logic [COORD_BITS:0]          o_box_h
);

    logic                         take;
    logic                         r_any;
    logic signed [COORD_BITS-1:0] r_lx;
    logic signed [COORD_BITS-1:0] r_hx;
    logic signed [COORD_BITS-1:0] r_ly;
    logic signed [COORD_BITS-1:0] r_hy;
    logic                         n_any;
    logic signed [COORD_BITS-1:0] n_lx;
    logic signed [COORD_BITS-1:0] n_hx;
    logic signed [COORD_BITS-1:0] n_ly;
    logic signed [COORD_BITS-1:0] n_hy;
    logic [COORD_BITS:0]          n_w;
    logic [COORD_BITS:0]          n_h;

    logic                         r_out_valid;
    logic                         r_found;
    logic signed [COORD_BITS-1:0] r_box_x;
    logic signed [COORD_BITS-1:0] r_box_y;
    logic [COORD_BITS:0]          r_box_w;
    logic [COORD_BITS:0]          r_box_h;

    assign take = i_ctl.valid && i_advance;

    always_comb begin
        n_any = r_any || i_ctl.counts;
        n_lx  = r_lx;
        n_hx  = r_hx;
        n_ly  = r_ly;
        n_hy  = r_hy;
        if (i_ctl.counts) begin
            if (!r_any) begin
                n_lx = i_point_x;
                n_hx = i_point_x;
                n_ly = i_point_y;
                n_hy = i_point_y;
            end else begin
                if (i_point_x < r_lx) n_lx = i_point_x;
                if (i_point_x > r_hx) n_hx = i_point_x;
                if (i_point_y < r_ly) n_ly = i_point_y;
                if (i_point_y > r_hy) n_hy = i_point_y;
            end
        end
        n_w = {n_hx[COORD_BITS-1], n_hx} - {n_lx[COORD_BITS-1], n_lx}
              + (COORD_BITS+1)'(1);
        n_h = {n_hy[COORD_BITS-1], n_hy} - {n_ly[COORD_BITS-1], n_ly}
              + (COORD_BITS+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (take) begin
            r_any <= i_ctl.last ? 1'b0 : n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_lx <= n_lx;
            r_hx <= n_hx;
            r_ly <= n_ly;
            r_hy <= n_hy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_ctl.last) begin
            r_found <= n_any;
            r_box_x <= n_any ? n_lx : '0;
            r_box_y <= n_any ? n_ly : '0;
            r_box_w <= n_any ? n_w : '0;
            r_box_h <= n_any ? n_h : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_box_x     = r_box_x;
    assign o_box_y     = r_box_y;
    assign o_box_w     = r_box_w;
    assign o_box_h     = r_box_h;

endmodule
